### sv/ppl_pkg.sv
// Package: shared constants, types and helpers for the probe pacer and loss tracker.
`default_nettype none
package ppl_pkg;

    localparam int HIST_DEPTH = 20;
    localparam int SEQ_W      = 48;
    localparam int CNT_W      = 32;
    localparam int REG_W      = 16;
    localparam int CMD_W      = 2;
    localparam int CLASS_W    = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int IN_DATA_W  = 152;
    localparam int OUT_DATA_W = 264;
    localparam int OUT_USER_W = 2;

    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ECHO  = 2'd2;

    localparam logic [CLASS_W-1:0] ECHO_NONE     = 2'd0;
    localparam logic [CLASS_W-1:0] ECHO_IN_ORDER = 2'd1;
    localparam logic [CLASS_W-1:0] ECHO_GAP      = 2'd2;
    localparam logic [CLASS_W-1:0] ECHO_DUP      = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_PKTS_PER_INTERVAL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL_MS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPORT_INTERVAL   = 2'd2;

    localparam logic [REG_W-1:0] PPI_RESET      = 16'd0;
    localparam logic [REG_W-1:0] INTERVAL_RESET = 16'd100;
    localparam logic [REG_W-1:0] REPORT_RESET   = 16'd1000;

    typedef struct packed {
        logic               send_valid;
        logic [SEQ_W-1:0]   send_sequence;
        logic [SEQ_W-1:0]   send_timestamp;
        logic               report_valid;
        logic [CNT_W-1:0]   lost_total;
        logic [SEQ_W-1:0]   sent_total;
        logic [CNT_W-1:0]   received_total;
        logic [CLASS_W-1:0] echo_class;
        logic [SEQ_W-1:0]   echo_latency;
    } result_t;

    function automatic logic [CNT_W-1:0] sat_add32(input logic [CNT_W-1:0] a,
                                                   input logic [SEQ_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b[CNT_W-1:0]};
        if ((|b[SEQ_W-1:CNT_W]) || sum[CNT_W])
            return '1;
        else
            return sum[CNT_W-1:0];
    endfunction

endpackage
`default_nettype wire

### sv/probe_pacer_loss_tracker_unit.sv
// Top level: token-bucket probe pacer with sequence-based loss tracking.
//
//  channel   | signals                                   | content
//  ----------+-------------------------------------------+-------------------------------
//  s_axis    | s_axis_tvalid/tready/tdata/tuser          | start, poll or echo command
//  m_axis    | m_axis_tvalid/tready/tdata/tuser          | one result per command
//  cfg       | cfg_wr_en, cfg_index, cfg_data            | pacing and report registers
//
// One transaction per cycle while s_axis_tready is high; each command updates all state
// in the cycle it is accepted; its result goes to the output register or skid entry.
// The sent-count history is a line of cells that advances one place per refill.
// Reset clears counters and history and loads config defaults; no clearing pass is needed.
// With the output stalled, one more command is accepted into the skid entry, then
// s_axis_tready drops until the output drains.
`default_nettype none
module probe_pacer_loss_tracker_unit (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // now_ms[47:0], tx_accepted[48], echo_sequence[96:49], echo_timestamp[144:97]
    input  wire logic [ppl_pkg::IN_DATA_W-1:0]  s_axis_tdata,
    // cmd[1:0]
    input  wire logic [ppl_pkg::CMD_W-1:0]      s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // send_sequence[47:0], send_timestamp[95:48], lost_total[127:96],
    // sent_total[175:128], received_total[207:176], echo_class[209:208],
    // echo_latency[257:210]
    output logic      [ppl_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    // send_valid[0], report_valid[1]
    output logic      [ppl_pkg::OUT_USER_W-1:0] m_axis_tuser,
    input  wire logic                           cfg_wr_en,
    input  wire logic [ppl_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [ppl_pkg::REG_W-1:0]      cfg_data
);
    import ppl_pkg::*;

    logic [REG_W-1:0] ppi_reg;
    logic [REG_W-1:0] interval_reg;
    logic [REG_W-1:0] report_int_reg;

    logic [SEQ_W-1:0] awaited_reg, awaited_next;
    logic [SEQ_W-1:0] sent_reg, sent_next;
    logic [REG_W-1:0] bucket_reg, bucket_next;
    logic [SEQ_W-1:0] refill_time_reg, refill_time_next;
    logic [SEQ_W-1:0] report_time_reg, report_time_next;
    logic [CNT_W-1:0] lost_reg, lost_next;
    logic [CNT_W-1:0] received_reg, received_next;

    logic [CMD_W-1:0] cmd;
    logic [SEQ_W-1:0] now_ms;
    logic             tx_accepted;
    logic [SEQ_W-1:0] echo_sequence;
    logic [SEQ_W-1:0] echo_timestamp;

    logic             in_fire;
    logic             hist_shift;
    logic             hist_clear;
    logic [SEQ_W-1:0] hist_q [HIST_DEPTH];
    logic [SEQ_W-1:0] oldest;
    logic [REG_W-1:0] bucket_after;
    logic [SEQ_W-1:0] echo_diff;
    logic [SEQ_W-1:0] latency;
    result_t          result;
    result_t          out_result;

    assign cmd            = s_axis_tuser;
    assign now_ms         = s_axis_tdata[47:0];
    assign tx_accepted    = s_axis_tdata[48];
    assign echo_sequence  = s_axis_tdata[96:49];
    assign echo_timestamp = s_axis_tdata[144:97];

    assign in_fire = s_axis_tvalid && s_axis_tready;
    assign oldest  = hist_q[HIST_DEPTH-1];

    genvar g;
    generate
        for (g = 0; g < HIST_DEPTH; g++)
        begin : g_hist
            if (g == 0)
            begin : g_head
                ppl_hist_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (hist_shift),
                    .clear_en (hist_clear),
                    .d        (sent_reg),
                    .q        (hist_q[g])
                );
            end
            else
            begin : g_body
                ppl_hist_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .shift_en (hist_shift),
                    .clear_en (hist_clear),
                    .d        (hist_q[g-1]),
                    .q        (hist_q[g])
                );
            end
        end
    endgenerate

    always_comb
    begin
        awaited_next     = awaited_reg;
        sent_next        = sent_reg;
        bucket_next      = bucket_reg;
        refill_time_next = refill_time_reg;
        report_time_next = report_time_reg;
        lost_next        = lost_reg;
        received_next    = received_reg;
        hist_shift       = 1'b0;
        hist_clear       = 1'b0;
        result           = '0;
        bucket_after     = bucket_reg;
        echo_diff        = echo_sequence - awaited_reg;
        latency          = now_ms - echo_timestamp;

        unique case (cmd)
            CMD_START:
            begin
                hist_clear       = 1'b1;
                awaited_next     = '0;
                sent_next        = '0;
                lost_next        = '0;
                received_next    = '0;
                bucket_next      = ppi_reg;
                refill_time_next = now_ms + {{(SEQ_W-REG_W){1'b0}}, interval_reg};
                report_time_next = now_ms + {{(SEQ_W-REG_W){1'b0}}, report_int_reg}
                                   - {{(SEQ_W-1){1'b0}}, 1'b1};
            end
            CMD_POLL:
            begin
                if (report_time_reg < now_ms)
                begin
                    result.report_valid   = 1'b1;
                    result.lost_total     = lost_reg;
                    result.sent_total     = sent_reg;
                    result.received_total = received_reg;
                    report_time_next = report_time_reg
                                       + {{(SEQ_W-REG_W){1'b0}}, report_int_reg};
                end
                if (refill_time_reg <= now_ms)
                begin
                    hist_shift       = 1'b1;
                    refill_time_next = refill_time_reg
                                       + {{(SEQ_W-REG_W){1'b0}}, interval_reg};
                    bucket_after     = ppi_reg;
                    if (oldest > awaited_reg)
                    begin
                        lost_next    = sat_add32(lost_reg, oldest - awaited_reg);
                        awaited_next = oldest;
                    end
                end
                bucket_next = bucket_after;
                if ((bucket_after != '0) && tx_accepted)
                begin
                    result.send_valid     = 1'b1;
                    result.send_sequence  = sent_reg;
                    result.send_timestamp = now_ms;
                    sent_next   = sent_reg + {{(SEQ_W-1){1'b0}}, 1'b1};
                    bucket_next = bucket_after - {{(REG_W-1){1'b0}}, 1'b1};
                end
            end
            CMD_ECHO:
            begin
                result.echo_latency = latency;
                if (echo_diff == '0)
                begin
                    result.echo_class = ECHO_IN_ORDER;
                    awaited_next  = awaited_reg + {{(SEQ_W-1){1'b0}}, 1'b1};
                    received_next = sat_add32(received_reg, {{(SEQ_W-1){1'b0}}, 1'b1});
                end
                else if (!echo_diff[SEQ_W-1])
                begin
                    result.echo_class = ECHO_GAP;
                    lost_next     = sat_add32(lost_reg, echo_diff);
                    received_next = sat_add32(received_reg, {{(SEQ_W-1){1'b0}}, 1'b1});
                    awaited_next  = echo_sequence + {{(SEQ_W-1){1'b0}}, 1'b1};
                end
                else
                begin
                    result.echo_class = ECHO_DUP;
                end
            end
            default:
            begin
                result.echo_class = ECHO_NONE;
            end
        endcase

        if (!in_fire)
        begin
            hist_shift = 1'b0;
            hist_clear = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            awaited_reg     <= '0;
            sent_reg        <= '0;
            bucket_reg      <= '0;
            refill_time_reg <= '0;
            report_time_reg <= '0;
            lost_reg        <= '0;
            received_reg    <= '0;
        end
        else if (in_fire)
        begin
            awaited_reg     <= awaited_next;
            sent_reg        <= sent_next;
            bucket_reg      <= bucket_next;
            refill_time_reg <= refill_time_next;
            report_time_reg <= report_time_next;
            lost_reg        <= lost_next;
            received_reg    <= received_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ppi_reg        <= PPI_RESET;
            interval_reg   <= INTERVAL_RESET;
            report_int_reg <= REPORT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_PKTS_PER_INTERVAL: ppi_reg        <= cfg_data;
                CFG_INTERVAL_MS:       interval_reg   <= cfg_data;
                CFG_REPORT_INTERVAL:   report_int_reg <= cfg_data;
                default:               ppi_reg        <= ppi_reg;
            endcase
        end
    end

    ppl_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_data   (result),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (out_result)
    );

    assign m_axis_tuser = {out_result.report_valid, out_result.send_valid};
    assign m_axis_tdata = {6'b0,
                           out_result.echo_latency,
                           out_result.echo_class,
                           out_result.received_total,
                           out_result.sent_total,
                           out_result.lost_total,
                           out_result.send_timestamp,
                           out_result.send_sequence};

endmodule
`default_nettype wire

### sv/ppl_hist_cell.sv
// One cell of the sent-count history line: holds one entry, passes it on at each refill, clears on start.
`default_nettype none
module ppl_hist_cell (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      shift_en,
    input  wire logic                      clear_en,
    input  wire logic [ppl_pkg::SEQ_W-1:0] d,
    output logic      [ppl_pkg::SEQ_W-1:0] q
);
    import ppl_pkg::*;

    logic [SEQ_W-1:0] entry_reg;
    logic [SEQ_W-1:0] entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (clear_en)
            entry_next = '0;
        else if (shift_en)
            entry_next = d;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            entry_reg <= '0;
        else
            entry_reg <= entry_next;
    end

    assign q = entry_reg;

endmodule
`default_nettype wire

### sv/ppl_out_stage.sv
// Output register with a skid entry for result transactions.
`default_nettype none
module ppl_out_stage (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire ppl_pkg::result_t in_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output ppl_pkg::result_t      out_data
);
    import ppl_pkg::*;

    logic    out_valid_reg;
    logic    out_valid_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    in_fire;

    assign in_ready = !skid_valid_reg;
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        out_data_next   = out_data_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready)
        begin
            if (skid_valid_reg)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (in_fire)
            begin
                out_data_next  = in_data;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (in_fire)
        begin
            skid_data_next  = in_data;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule
`default_nettype wire
